### design/fowmm_pkg.sv
// Shared types, constants and the tile palette of the minimap renderer.
`default_nettype none
package fowmm_pkg;

  // Transaction payloads
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [4:0] tile_kind;
    logic [5:0] win_x;
    logic [5:0] win_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } out_item_t;

  // Command codes
  localparam logic [1:0] CMD_TILE  = 2'd0;
  localparam logic [1:0] CMD_PLAY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Fixed widths: offsets within circle or window, signed map coordinates
  localparam int OFS_W = 8;
  localparam int CRD_W = 12;

  localparam logic [5:0]  RADIUS_RST = 6'd8;
  localparam logic [31:0] FOG_PIX    = 32'h0A0A_0FC8;
  localparam logic [31:0] CLEAR_PIX  = 32'h0000_0000;

  // RGBA colour of a tile kind; unknown kinds give an all-zero pixel
  function automatic logic [31:0] kind_colour(input logic [4:0] kind);
    logic [31:0] c;
    case (kind)
      5'd1:    c = 32'h282832FF;
      5'd2:    c = 32'h787882FF;
      5'd3:    c = 32'h1E0F3CFF;
      5'd4:    c = 32'h82501EFF;
      5'd5:    c = 32'hE6E600FF;
      5'd6:    c = 32'h00E6E6FF;
      5'd7:    c = 32'h1450C8FF;
      5'd8:    c = 32'hFF3C00FF;
      5'd9:    c = 32'h146414FF;
      5'd10:   c = 32'h96C8FFFF;
      5'd11:   c = 32'hC8B464FF;
      5'd12:   c = 32'hC8B414FF;
      5'd13:   c = 32'h50B4FFFF;
      5'd14:   c = 32'hC832FFFF;
      5'd15:   c = 32'h32FF82FF;
      5'd16:   c = 32'hC8321EFF;
      5'd17:   c = 32'h644B32FF;
      5'd18:   c = 32'h4B4B4BFF;
      5'd19:   c = 32'h4B3219FF;
      5'd20:   c = 32'hE6E6E6FF;
      5'd21:   c = 32'h414141FF;
      default: c = 32'h00000000;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### design/fowmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fowmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### design/fowmm_shade.sv
// Window pixel colour from map, explored and tile data of one cell.
`default_nettype none
module fowmm_shade (
  input  wire logic        in_map_i,
  input  wire logic        explored_i,
  input  wire logic        far_i,
  input  wire logic [4:0]  kind_i,
  output logic      [31:0] pix_o
);
  import fowmm_pkg::*;

  logic [31:0] col;

  always_comb begin
    col = kind_colour(kind_i);
    // beyond vision: halve rgb, keep alpha
    if (far_i) begin
      col = ((col >> 1) & 32'h7F7F7F00) | (col & 32'h000000FF);
    end
    if (!in_map_i) begin
      pix_o = CLEAR_PIX;
    end else if (!explored_i) begin
      pix_o = FOG_PIX;
    end else begin
      pix_o = col;
    end
  end
endmodule
`default_nettype wire

### design/fog_of_war_minimap_renderer.sv
// Top level: command sequencer around tile, explored and window memories.
// A player update marks the vision circle and, if the position moved, then rebuilds the
// window; the sequencer passes through a finishing state before it returns to idle.
// Clear fog and reset each run a clearing pass over the explored memory, one entry per
// cycle; no transaction is accepted meanwhile.
// One command is processed at a time; the result register frees the input side.
`default_nettype none
module fog_of_war_minimap_renderer #(
  parameter int MAP_W      = 256,
  parameter int MAP_H      = 256,
  parameter int WIN_RADIUS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire fowmm_pkg::in_item_t   in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output fowmm_pkg::out_item_t       out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [5:0]            cfg_data_i
);
  import fowmm_pkg::*;

  localparam int WSIDE  = 2 * WIN_RADIUS + 1;
  localparam int WDEPTH = WSIDE * WSIDE;
  localparam int MDEPTH = MAP_W * MAP_H;
  localparam int AW     = $clog2(MDEPTH);
  localparam int WIW    = $clog2(WDEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SWEEP = 3'd1;
  localparam logic [2:0] ST_MARK  = 3'd2;
  localparam logic [2:0] ST_BUILD = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_RDW   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [5:0]  rad_q;
  logic [11:0] rsq_q, rsq_d;
  logic [7:0]  px_q, px_d, py_q, py_d;
  logic signed [OFS_W-1:0] dx_q, dx_d, dy_q, dy_d;
  logic        lv_q, lv_d;
  logic [7:0]  lcol_q, lcol_d, lrow_q, lrow_d;
  logic [AW-1:0]  swp_q, swp_d;
  logic [WIW-1:0] widx_q, widx_d;
  logic        pend_q, pend_d;
  logic [31:0] res_q, res_d;
  logic        rdok_q, rdok_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  // rebuild pipeline stage
  logic           bv_q, bv_d, bmap_q, bmap_d, bfar_q, bfar_d;
  logic [WIW-1:0] bidx_q, bidx_d;

  // memory ports
  logic          exp_we, exp_wd, exp_rd;
  logic [AW-1:0] exp_wa;
  logic          til_we;
  logic [4:0]    til_rd;
  logic          win_we;
  logic [WIW-1:0] win_ra;
  logic [31:0]   win_rd, shade_pix;

  // Current cell: map coordinates, address, distance test
  logic signed [CRD_W-1:0] mx, my;
  logic          cell_in_map;
  logic [AW-1:0] cell_addr;
  logic signed [2*OFS_W-1:0] sqx, sqy;
  logic [2*OFS_W:0] dd;
  logic          cell_far;
  logic signed [OFS_W-1:0] rad_s, wr_s;

  assign rad_s = OFS_W'(signed'({1'b0, rad_q}));
  assign wr_s  = OFS_W'(WIN_RADIUS);

  always_comb begin
    mx = signed'(CRD_W'(px_q)) + CRD_W'(dx_q);
    my = signed'(CRD_W'(py_q)) + CRD_W'(dy_q);
    cell_in_map = (mx >= 0) && (mx < signed'(CRD_W'(MAP_W))) &&
                  (my >= 0) && (my < signed'(CRD_W'(MAP_H)));
    cell_addr = AW'(32'(my[CRD_W-2:0]) * 32'(MAP_W) + 32'(mx[CRD_W-2:0]));
    sqx = dx_q * dx_q;
    sqy = dy_q * dy_q;
    dd  = {1'b0, sqx} + {1'b0, sqy};
    cell_far = dd > (2*OFS_W+1)'(rsq_q);
  end

  // Configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= RADIUS_RST;
    end else if (cfg_valid_i) begin
      rad_q <= cfg_data_i;
    end
  end

  // Tile write address from the input transaction
  logic          in_acc, tile_ok;
  logic [AW-1:0] tile_addr;
  logic [31:0]   rd_lin;
  assign in_acc    = in_valid_i && !in_stall_o;
  assign tile_ok   = (32'(in_data_i.pos_x) < 32'(MAP_W)) &&
                     (32'(in_data_i.pos_y) < 32'(MAP_H));
  assign tile_addr = AW'(32'(in_data_i.pos_y) * 32'(MAP_W) + 32'(in_data_i.pos_x));
  assign rd_lin    = 32'(in_data_i.win_y) * 32'(WSIDE) + 32'(in_data_i.win_x);
  assign in_stall_o = (state_q != ST_IDLE);

  // Sequencer
  always_comb begin
    state_d = state_q; rsq_d = rsq_q; px_d = px_q; py_d = py_q;
    dx_d = dx_q; dy_d = dy_q; lv_d = lv_q; lcol_d = lcol_q; lrow_d = lrow_q;
    swp_d = swp_q; widx_d = widx_q; pend_d = pend_q; res_d = res_q;
    rdok_d = rdok_q; out_d = out_q; bv_d = 1'b0; bmap_d = bmap_q;
    bfar_d = bfar_q; bidx_d = bidx_q;
    out_valid_d = out_valid_q && out_stall_i;
    exp_we = 1'b0; exp_wd = 1'b0; exp_wa = cell_addr;
    til_we = 1'b0;
    win_ra = WIW'(rd_lin);
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pend_d = 1'b1;
          res_d  = CLEAR_PIX;
          px_d   = in_data_i.pos_x;
          py_d   = in_data_i.pos_y;
          rsq_d  = 12'(rad_q) * 12'(rad_q);
          case (in_data_i.cmd)
            CMD_TILE: begin
              til_we  = tile_ok;
              state_d = ST_FIN;
            end
            CMD_PLAY: begin
              dx_d = -OFS_W'(signed'({1'b0, rad_q}));
              dy_d = -OFS_W'(signed'({1'b0, rad_q}));
              state_d = ST_MARK;
            end
            CMD_CLEAR: begin
              lv_d = 1'b0; lcol_d = '0; lrow_d = '0;
              swp_d = '0;
              state_d = ST_SWEEP;
            end
            default: begin
              rdok_d  = lv_q && (32'(in_data_i.win_x) < 32'(WSIDE)) &&
                        (32'(in_data_i.win_y) < 32'(WSIDE));
              state_d = ST_RDW;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        exp_we = 1'b1; exp_wd = 1'b0; exp_wa = swp_q;
        swp_d  = swp_q + 1'b1;
        if (swp_q == AW'(MDEPTH - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_MARK: begin
        exp_we = cell_in_map && !cell_far; exp_wd = 1'b1;
        if (dx_q == rad_s) begin
          dx_d = -rad_s;
          dy_d = dy_q + 1'b1;
          if (dy_q == rad_s) begin
            if (lv_q && lcol_q == px_q && lrow_q == py_q) begin
              state_d = ST_FIN;
            end else begin
              lv_d = 1'b1; lcol_d = px_q; lrow_d = py_q;
              dx_d = -wr_s; dy_d = -wr_s; widx_d = '0;
              state_d = ST_BUILD;
            end
          end
        end else begin
          dx_d = dx_q + 1'b1;
        end
      end
      ST_BUILD: begin
        bv_d = 1'b1; bmap_d = cell_in_map; bfar_d = cell_far; bidx_d = widx_q;
        widx_d = widx_q + 1'b1;
        if (dx_q == wr_s) begin
          dx_d = -wr_s;
          dy_d = dy_q + 1'b1;
          if (dy_q == wr_s) begin
            state_d = ST_DRAIN;
          end
        end else begin
          dx_d = dx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FIN;
      end
      ST_RDW: begin
        res_d   = rdok_q ? win_rd : CLEAR_PIX;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!pend_q) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          pend_d      = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign win_we = bv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      swp_q <= '0;
      lv_q <= 1'b0; lcol_q <= '0; lrow_q <= '0;
      pend_q <= 1'b0; out_valid_q <= 1'b0; bv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      swp_q <= swp_d;
      lv_q <= lv_d; lcol_q <= lcol_d; lrow_q <= lrow_d;
      pend_q <= pend_d; out_valid_q <= out_valid_d; bv_q <= bv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsq_q <= rsq_d; px_q <= px_d; py_q <= py_d; dx_q <= dx_d; dy_q <= dy_d;
    widx_q <= widx_d; res_q <= res_d; rdok_q <= rdok_d; out_q <= out_d;
    bmap_q <= bmap_d; bfar_q <= bfar_d; bidx_q <= bidx_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Memories
  fowmm_ram #(.WIDTH(1), .DEPTH(MDEPTH)) u_explored (
    .clk_i, .we_i(exp_we), .waddr_i(exp_wa), .wdata_i(exp_wd),
    .raddr_i(cell_addr), .rdata_o(exp_rd)
  );

  fowmm_ram #(.WIDTH(5), .DEPTH(MDEPTH)) u_tiles (
    .clk_i, .we_i(til_we), .waddr_i(tile_addr), .wdata_i(in_data_i.tile_kind),
    .raddr_i(cell_addr), .rdata_o(til_rd)
  );

  fowmm_shade u_shade (
    .in_map_i(bmap_q), .explored_i(exp_rd), .far_i(bfar_q), .kind_i(til_rd),
    .pix_o(shade_pix)
  );

  fowmm_ram #(.WIDTH(32), .DEPTH(WDEPTH)) u_window (
    .clk_i, .we_i(win_we), .waddr_i(bidx_q), .wdata_i(shade_pix),
    .raddr_i(win_ra), .rdata_o(win_rd)
  );
endmodule
`default_nettype wire

### dv/fog_of_war_minimap_renderer_test.sv
// Self-checking testbench of the fog-of-war minimap renderer: directed table, then random and special phases.
`default_nettype none
module fog_of_war_minimap_renderer_test;
  import fowmm_pkg::*;

  localparam int MAP_SIDE  = 256;
  localparam int WIN_R     = 16;
  localparam int WIN_SIDE  = 2 * WIN_R + 1;
  localparam int QUIET_MAX = 250000;
  localparam int LONG_HOLD = 300;

  // Palette of tile kinds 0..21, RGBA; higher kinds give an all-zero pixel
  localparam logic [31:0] TILE_RGBA [22] = '{
    32'h00000000, 32'h282832FF, 32'h787882FF, 32'h1E0F3CFF, 32'h82501EFF, 32'hE6E600FF,
    32'h00E6E6FF, 32'h1450C8FF, 32'hFF3C00FF, 32'h146414FF, 32'h96C8FFFF, 32'hC8B464FF,
    32'hC8B414FF, 32'h50B4FFFF, 32'hC832FFFF, 32'h32FF82FF, 32'hC8321EFF, 32'h644B32FF,
    32'h4B4B4BFF, 32'h4B3219FF, 32'hE6E6E6FF, 32'h414141FF};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [5:0] cfg_data = '0;

  fog_of_war_minimap_renderer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow state of the renderer
  bit          explored  [MAP_SIDE*MAP_SIDE];
  logic [4:0]  tile_kind [MAP_SIDE*MAP_SIDE];
  bit          tile_set  [MAP_SIDE*MAP_SIDE];
  logic [31:0] win_pix   [WIN_SIDE*WIN_SIDE];
  bit          have_last;
  int          last_x, last_y;
  int          vis_radius = RADIUS_RST;

  out_item_t pixel_q [$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  bit hold_req = 1'b0;
  int cur_x = 0, cur_y = 0;

  function automatic bit on_map(int x, int y);
    return x >= 0 && x < MAP_SIDE && y >= 0 && y < MAP_SIDE;
  endfunction

  // Colour of one window cell at offset (dx,dy) from the player
  function automatic logic [31:0] cell_colour(int px, int py, int dx, int dy);
    int mx, my;
    logic [31:0] c;
    mx = px + dx;
    my = py + dy;
    if (!on_map(mx, my)) return CLEAR_PIX;
    if (!explored[my*MAP_SIDE+mx]) return FOG_PIX;
    c = (tile_kind[my*MAP_SIDE+mx] < 22) ? TILE_RGBA[tile_kind[my*MAP_SIDE+mx]] : '0;
    if (dx*dx + dy*dy > vis_radius*vis_radius)
      c = {1'b0, c[31:25], 1'b0, c[23:17], 1'b0, c[15:9], c[7:0]};
    return c;
  endfunction

  // Apply one command to the shadow state and return the pixel it yields
  function automatic out_item_t render_step(in_item_t it);
    int px, py, r;
    out_item_t o;
    o = '0;
    px = it.pos_x;
    py = it.pos_y;
    r = vis_radius;
    case (it.cmd)
      CMD_TILE: begin
        tile_kind[py*MAP_SIDE+px] = it.tile_kind;
        tile_set[py*MAP_SIDE+px] = 1'b1;
      end
      CMD_PLAY: begin
        for (int dy = -r; dy <= r; dy++)
          for (int dx = -r; dx <= r; dx++)
            if (dx*dx + dy*dy <= r*r && on_map(px+dx, py+dy))
              explored[(py+dy)*MAP_SIDE+px+dx] = 1'b1;
        if (!(have_last && last_x == px && last_y == py)) begin
          have_last = 1'b1;
          last_x = px;
          last_y = py;
          for (int dy = -WIN_R; dy <= WIN_R; dy++)
            for (int dx = -WIN_R; dx <= WIN_R; dx++)
              win_pix[(dy+WIN_R)*WIN_SIDE+dx+WIN_R] = cell_colour(px, py, dx, dy);
        end
      end
      CMD_CLEAR: begin
        foreach (explored[i]) explored[i] = 1'b0;
        foreach (win_pix[i]) win_pix[i] = '0;
        have_last = 1'b0;
        last_x = 0;
        last_y = 0;
      end
      default: begin
        if (it.win_x < WIN_SIDE && it.win_y < WIN_SIDE)
          o = win_pix[it.win_y*WIN_SIDE+it.win_x];
      end
    endcase
    return o;
  endfunction

  // Offer one transaction; the pixel expected is predicted, or typed when given
  task automatic offer(in_item_t it, bit typed, logic [31:0] want);
    out_item_t p;
    p = render_step(it);
    if (typed) p = want;
    pixel_q.push_back(p);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic offer_cmd(logic [1:0] c, int x, int y, int k, int wx, int wy);
    in_item_t it;
    it = '{cmd: c, pos_x: x[7:0], pos_y: y[7:0], tile_kind: k[4:0],
           win_x: wx[5:0], win_y: wy[5:0]};
    offer(it, 1'b0, '0);
  endtask

  // Write a random kind into every never-written cell that an update may explore
  task automatic cover_circle(int px, int py);
    int r;
    r = vis_radius;
    for (int dy = -r; dy <= r; dy++)
      for (int dx = -r; dx <= r; dx++)
        if (dx*dx + dy*dy <= r*r && on_map(px+dx, py+dy) &&
            !tile_set[(py+dy)*MAP_SIDE+px+dx])
          offer_cmd(CMD_TILE, px+dx, py+dy, $urandom_range(0, 31), 0, 0);
  endtask

  task automatic settle();
    wait (pixel_q.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_radius(int r);
    settle();
    cfg_valid = 1'b1;
    cfg_data = r[5:0];
    do @(posedge clk); while (!cfg_ready);
    vis_radius = r;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_mode(int m);
    send_idle = (m == 1 || m == 3) ? ((m == 3) ? 34 : 65) : 0;
    recv_idle = (m == 2 || m == 3) ? ((m == 3) ? 34 : 65) : 0;
  endtask

  task automatic update_at(int x, int y);
    cover_circle(x, y);
    offer_cmd(CMD_PLAY, x, y, $urandom_range(0, 31), $urandom_range(0, 63),
              $urandom_range(0, 63));
  endtask

  // Player kept near the map corner so that few cells need covering tile writes
  task automatic random_item();
    int p;
    p = $urandom_range(0, 99);
    if (p < 30) begin
      if ($urandom_range(0, 9) == 0) begin
        cur_x = $urandom_range(251, 255);
        cur_y = $urandom_range(251, 255);
      end else begin
        cur_x = cur_x + $urandom_range(0, 4) - 2;
        cur_y = cur_y + $urandom_range(0, 4) - 2;
        cur_x = (cur_x < 251) ? 251 : (cur_x > 255) ? 255 : cur_x;
        cur_y = (cur_y < 251) ? 251 : (cur_y > 255) ? 255 : cur_y;
      end
      update_at(cur_x, cur_y);
    end else if (p < 38) begin
      update_at(cur_x, cur_y);
    end else if (p < 80) begin
      offer_cmd(CMD_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 31), $urandom_range(0, 40), $urandom_range(0, 40));
    end else if (p < 99) begin
      offer_cmd(CMD_TILE, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
    end else begin
      offer_cmd(CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255), 0, 0, 0);
    end
  endtask

  // Directed table
  typedef struct {
    logic [1:0]  c;
    int          x, y, k, wx, wy;
    bit          typed;
    logic [31:0] want;
  } row_t;

  localparam int N_ROWS = 22;
  row_t rows [N_ROWS] = '{
    '{CMD_READ,    0,   0,  0,  0,  0, 1, 32'h0},         // window zero after reset
    '{CMD_READ,    0,   0,  0, 32, 32, 1, 32'h0},
    '{CMD_READ,    0,   0,  0, 63, 63, 1, 32'h0},         // outside window
    '{CMD_READ,    0,   0,  0, 33,  5, 1, 32'h0},
    '{CMD_TILE,    0,   0, 21,  0,  0, 1, 32'h0},
    '{CMD_TILE,    1,   0, 31,  0,  0, 1, 32'h0},         // unknown kind
    '{CMD_PLAY,    0,   0,  0,  0,  0, 1, 32'h0},
    '{CMD_READ,    0,   0,  0, 16, 16, 1, 32'h414141FF},
    '{CMD_READ,    0,   0,  0, 17, 16, 1, 32'h0},         // unknown kind as all-zero pixel
    '{CMD_READ,    0,   0,  0, 15, 16, 1, 32'h0},         // off the map
    '{CMD_READ,    0,   0,  0, 18, 16, 1, FOG_PIX},
    '{CMD_READ,    0,   0,  0,  0,  0, 1, 32'h0},
    '{CMD_PLAY,    0,   0,  0,  0,  0, 1, 32'h0},         // same position
    '{CMD_TILE,    0,   0,  2,  0,  0, 1, 32'h0},
    '{CMD_READ,    0,   0,  0, 16, 16, 1, 32'h414141FF},  // window not rebuilt
    '{CMD_CLEAR, 255, 255, 31, 63, 63, 1, 32'h0},
    '{CMD_READ,    0,   0,  0, 16, 16, 1, 32'h0},
    '{CMD_TILE,  255, 255, 20,  0,  0, 1, 32'h0},
    '{CMD_PLAY,  255, 255,  0,  0,  0, 1, 32'h0},
    '{CMD_READ,    0,   0,  0, 16, 16, 1, 32'hE6E6E6FF},
    '{CMD_READ,    0,   0,  0, 32, 32, 1, 32'h0},
    '{CMD_READ,    0,   0,  0, 16, 14, 1, FOG_PIX}
  };

  // Receiver: random stalls, or one long hold-off on request
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(0, 99) < recv_idle);
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h, want %0h", what, got, want);
    errors++;
  endtask

  // Result check and watchdog
  int quiet = 0;
  always @(posedge clk) begin
    out_item_t w;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected transaction", out_data, '0);
      end else begin
        w = pixel_q.pop_front();
        if (out_data.red !== w.red) report_mismatch("red", out_data.red, w.red);
        if (out_data.green !== w.green) report_mismatch("green", out_data.green, w.green);
        if (out_data.blue !== w.blue) report_mismatch("blue", out_data.blue, w.blue);
        if (out_data.alpha !== w.alpha) report_mismatch("alpha", out_data.alpha, w.alpha);
      end
    end
    if (quiet >= QUIET_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at a small radius
    set_mode(0);
    write_radius(1);
    foreach (rows[i]) begin
      if (rows[i].c == CMD_PLAY) cover_circle(rows[i].x, rows[i].y);
      it = '{cmd: rows[i].c, pos_x: rows[i].x[7:0], pos_y: rows[i].y[7:0],
             tile_kind: rows[i].k[4:0], win_x: rows[i].wx[5:0], win_y: rows[i].wy[5:0]};
      offer(it, rows[i].typed, rows[i].want);
    end
    cur_x = 255;
    cur_y = 255;

    // Random phases over radius and idling mode
    for (int ph = 0; ph < 5; ph++) begin
      write_radius((ph == 0) ? 2 : (ph == 1) ? 5 : (ph == 2) ? 0 : (ph == 3) ? 3 : 8);
      set_mode((ph == 4) ? 0 : ph);
      repeat (32) random_item();
    end

    // Large radii: mark only, at the last position, then clear before any rebuild
    set_mode(3);
    write_radius(1);
    update_at(cur_x, cur_y);
    write_radius(63);
    offer_cmd(CMD_PLAY, cur_x, cur_y, 0, 0, 0);
    offer_cmd(CMD_CLEAR, 0, 0, 0, 0, 0);
    write_radius(1);
    update_at(cur_x, cur_y);
    write_radius(32);
    offer_cmd(CMD_PLAY, cur_x, cur_y, 0, 0, 0);
    offer_cmd(CMD_CLEAR, 0, 0, 0, 0, 0);

    // Back-pressure: long receiver hold-off while reads keep coming
    write_radius(4);
    set_mode(0);
    update_at(cur_x, cur_y);
    settle();
    hold_req = 1'b1;
    repeat (30) offer_cmd(CMD_READ, 0, 0, 0, $urandom_range(0, 32), $urandom_range(0, 32));

    settle();
    repeat (50) @(posedge clk);
    if (errors == 0 && pixel_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
